// File: rtl/core/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and constants of the sorted list engine: sizes, operation
// and status codes, state machine states and the per-cell control group.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_UPDATE = 1'b1
  } state_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic sample;  // latch compare flags against the incoming value
    logic ins;     // apply an insert
    logic del;     // apply a delete (only when a match exists)
  } cell_ctrl_t;

endpackage

// File: rtl/core/slid_cell.sv
// ----------------------------------------------------------------------------
// slid_cell
// One slot of the sorted chain. Holds an entry and its valid bit, compares
// against the broadcast value, and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module slid_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  slid_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] value_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] left_entry_i,
  input  logic                                left_valid_i,
  input  logic                                left_lt_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] right_entry_i,
  input  logic                                right_valid_i,
  output logic signed [slid_pkg::VALUE_W-1:0] entry_o,
  output logic                                valid_o,
  output logic                                lt_o,
  output logic                                eq_o
);
  import slid_pkg::*;

  logic signed [VALUE_W-1:0] entry_q;
  logic                      valid_q;
  logic                      lt_q;
  logic                      eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      if (ctrl_i.sample) begin
        lt_q <= valid_q && (entry_q < value_i);
        eq_q <= valid_q && (entry_q == value_i);
      end
      // Cells holding smaller values stay put; the rest move one slot.
      if (ctrl_i.ins) begin
        valid_q <= valid_q | left_valid_i;
      end else if (ctrl_i.del && !lt_q) begin
        valid_q <= right_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !lt_q) begin
      entry_q <= left_lt_i ? value_i : left_entry_i;
    end else if (ctrl_i.del && !lt_q) begin
      entry_q <= right_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

// File: rtl/core/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded table of signed Q8.8 values kept in ascending order in a chain of
// cells. Inserts go in front of the first entry not smaller than the value;
// deletes remove the first equal entry. Each request answers with a status
// and the resulting count.
// ----------------------------------------------------------------------------
// A request is accepted only in the idle state, so a new one is not taken until the
// previous update is done; all cells compare in the accept cycle and shift together
// in the update state.
// A result not taken by the sink stalls the update cycle, not the accept.
// Reset clears every valid bit and the count; the table starts empty.
module sorted_list_insert_delete (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [15:0]                       s_axis_tdata_i,  // [15:0] value
  input  logic                              s_axis_tuser_i,  // [0] func
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,  // [4:0] count
  output logic [slid_pkg::STATUS_W-1:0]     m_axis_tuser_o   // [2:0] status
);
  import slid_pkg::*;

  state_e state_q, state_d;

  op_e                       op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]          occ_q, occ_d;
  logic                      m_valid_q;
  status_e                   status_q, status_d;
  logic [COUNT_W-1:0]        count_q;

  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] bcast_value;
  logic                      accept;
  logic                      commit;
  logic                      found;
  logic                      full;
  logic                      empty;
  logic [CNT_W+COUNT_W-1:0]  count_wide;

  logic signed [VALUE_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]       valid_vec;
  logic [CAPACITY-1:0]       lt_vec;
  logic [CAPACITY-1:0]       eq_vec;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_entry;
    logic                      left_valid;
    logic                      left_lt;
    logic signed [VALUE_W-1:0] right_entry;
    logic                      right_valid;

    if (i == 0) begin : g_head
      // The head sees an always-smaller, always-valid neighbor on its left.
      assign left_entry = '0;
      assign left_valid = 1'b1;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry_w[i-1];
      assign left_valid = valid_vec[i-1];
      assign left_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_entry = entry_w[i+1];
      assign right_valid = valid_vec[i+1];
    end

    slid_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .value_i       (bcast_value),
      .left_entry_i  (left_entry),
      .left_valid_i  (left_valid),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .right_valid_i (right_valid),
      .entry_o       (entry_w[i]),
      .valid_o       (valid_vec[i]),
      .lt_o          (lt_vec[i]),
      .eq_o          (eq_vec[i])
    );
  end

  assign found = |eq_vec;
  assign full  = valid_vec[CAPACITY-1];
  assign empty = !valid_vec[0];

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid_i) state_d = S_UPDATE;
      S_UPDATE: if (!m_valid_q || m_axis_tready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    commit          = 1'b0;
    bcast_value     = value_q;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        bcast_value     = s_axis_tdata_i;
      end
      S_UPDATE: begin
        commit = !m_valid_q || m_axis_tready_i;
      end
      default: ;
    endcase
    accept      = s_axis_tvalid_i && s_axis_tready_o;
    ctrl.sample = accept;
    ctrl.ins    = commit && (op_q == OP_INSERT) && !full;
    ctrl.del    = commit && (op_q == OP_DELETE) && found;
  end

  always_comb begin
    occ_d    = occ_q;
    status_d = ST_INSERTED;
    if (op_q == OP_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_INSERTED;
        occ_d    = occ_q + 1'b1;
      end
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else if (found) begin
      status_d = ST_DELETED;
      occ_d    = occ_q - 1'b1;
    end else begin
      status_d = ST_NOT_FOUND;
    end
  end

  assign count_wide = {{COUNT_W{1'b0}}, occ_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        occ_q     <= occ_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(s_axis_tuser_i);
      value_q <= s_axis_tdata_i;
    end
    if (commit) begin
      status_q <= status_d;
      count_q  <= count_wide[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {{(8-COUNT_W){1'b0}}, count_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Held entries always form an unbroken run from the head of the chain.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("valid bits are not a prefix");

  // The count register tracks the number of valid cells.
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(occ_q))
    else $error("count disagrees with valid cells");

  // A match can only be flagged when the table holds something.
  a_no_match_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE && empty) |-> !found)
    else $error("match flagged in empty table");

  // An insert never runs into a full table and a delete never without a match.
  a_ctrl_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && full) && !(ctrl.del && !found) && !(ctrl.ins && ctrl.del))
    else $error("illegal cell update");

  // A pending result is not overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |-> !commit)
    else $error("result overwritten while stalled");

endmodule

// File: bench/tb_sorted_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete
// Drives insert and delete requests into the sorted table and keeps a copy of
// the table here. Each returned status and count is checked in order against
// that copy. Directed edge cases come first, then random mixes that swing the
// table between empty and full under changing back-pressure.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_delete;
  import slid_pkg::*;

  typedef logic signed [VALUE_W-1:0] q8_8_t;

  typedef struct {
    status_e          status;
    logic [COUNT_W-1:0] count;
  } table_reply_t;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned SETTLE_TICKS = 8;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;     // [15:0] value
  logic        s_axis_tuser_i  = 1'b0;   // [0] func
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;           // [4:0] count
  logic [STATUS_W-1:0] m_axis_tuser_o;   // [2:0] status

  // Local copy of the table, ascending from slot 0.
  q8_8_t        table_vals [CAPACITY];
  int           table_len = 0;
  table_reply_t replies_due[$];

  int unsigned  send_idle_pct = 18;
  int unsigned  recv_idle_pct = 48;
  int unsigned  mismatch_count = 0;
  int unsigned  stall_cycles = 0;

  sorted_list_insert_delete uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic status_e apply_request(op_e op, q8_8_t v);
    int pos;
    pos = 0;
    if (op == OP_INSERT) begin
      if (table_len >= CAPACITY) return ST_FULL;
      while (pos < table_len && v > table_vals[pos]) pos++;
      for (int k = table_len; k > pos; k--) table_vals[k] = table_vals[k-1];
      table_vals[pos] = v;
      table_len++;
      return ST_INSERTED;
    end
    if (table_len == 0) return ST_EMPTY;
    while (pos < table_len && table_vals[pos] != v) pos++;
    if (pos >= table_len) return ST_NOT_FOUND;
    for (int k = pos; k + 1 < table_len; k++) table_vals[k] = table_vals[k+1];
    table_len--;
    return ST_DELETED;
  endfunction

  // Half of the values come from a narrow set so duplicates are common.
  function automatic q8_8_t pick_value();
    case ($urandom_range(3))
      0, 1:    return q8_8_t'($urandom);
      2:       return q8_8_t'(($urandom_range(8) - 4) * 256);
      default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic send_request(input op_e op, input q8_8_t v);
    table_reply_t reply;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    reply.status = apply_request(op, v);
    reply.count  = COUNT_W'(table_len);
    replies_due.push_back(reply);
  endtask

  // Sink back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (replies_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: status %0d count %0d",
                   m_axis_tuser_o, m_axis_tdata_o[4:0]);
      end else begin
        want = replies_due.pop_front();
        if (m_axis_tuser_o !== want.status || m_axis_tdata_o[4:0] !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: status exp %0d got %0d, count exp %0d got %0d",
                     want.status, m_axis_tuser_o, want.count, m_axis_tdata_o[4:0]);
        end
      end
    end
  end

  // Ends the run if neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (rst_ni) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Empty delete, extremes, duplicates, absent value, head and tail removal.
  task automatic test_edges();
    send_request(OP_DELETE, 16'sh0000);
    send_request(OP_INSERT, 16'sh7FFF);
    send_request(OP_INSERT, 16'sh8000);
    send_request(OP_INSERT, 16'sh0000);
    send_request(OP_INSERT, 16'sh0000);
    send_request(OP_INSERT, 16'shFFFF);
    send_request(OP_INSERT, 16'sh0001);
    send_request(OP_DELETE, 16'sh1234);
    send_request(OP_DELETE, 16'sh8000);
    send_request(OP_DELETE, 16'sh7FFF);
    send_request(OP_DELETE, 16'sh0000);
  endtask

  // Fill every slot, then push against the full table.
  task automatic test_fill_to_capacity();
    while (table_len < CAPACITY) send_request(OP_INSERT, pick_value());
    send_request(OP_INSERT, 16'sh8000);
    send_request(OP_INSERT, 16'sh7FFF);
  endtask

  // The table swings between filling and draining so both ends are hit often.
  task automatic test_random_mix(input int n_items);
    bit    filling;
    int    insert_pct;
    op_e   op;
    q8_8_t v;
    filling = (table_len < CAPACITY / 2);
    for (int i = 0; i < n_items; i++) begin
      if (table_len >= CAPACITY) filling = 1'b0;
      else if (table_len == 0) filling = 1'b1;
      insert_pct = filling ? 70 : 30;
      if ($urandom_range(99) < insert_pct) begin
        op = OP_INSERT;
        v  = pick_value();
      end else begin
        op = OP_DELETE;
        if (table_len > 0 && $urandom_range(3) != 0)
          v = table_vals[$urandom_range(table_len - 1)];
        else
          v = pick_value();
      end
      send_request(op, v);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 18;
    recv_idle_pct = 48;
    test_edges();
    test_fill_to_capacity();
    test_random_mix(300);

    send_idle_pct = 48;
    recv_idle_pct = 18;
    test_random_mix(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(300);

    s_axis_tvalid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
